// File: design/ule_pkg.sv
// Shared types and constants for the UTF-8 terminal line editor.
package ule_pkg;

    // Keyboard byte codes with a meaning to the editor
    localparam logic [7:0] CH_ESC       = 8'h1b;
    localparam logic [7:0] CH_CSI_OPEN  = 8'h5b;
    localparam logic [7:0] CH_SS3_OPEN  = 8'h4f;
    localparam logic [7:0] CH_CR        = 8'h0d;
    localparam logic [7:0] CH_LF        = 8'h0a;
    localparam logic [7:0] CH_CTRL_C    = 8'h03;
    localparam logic [7:0] CH_CTRL_D    = 8'h04;
    localparam logic [7:0] CH_BS        = 8'h08;
    localparam logic [7:0] CH_DEL       = 8'h7f;
    localparam logic [7:0] CH_CTRL_U    = 8'h15;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    // Result kinds on the output stream
    typedef enum logic [2:0] {
        KIND_ECHO  = 3'd0,
        KIND_ERASE = 3'd1,
        KIND_LINE  = 3'd2,
        KIND_ENDED = 3'd3,
        KIND_INTR  = 3'd4,
        KIND_EOF   = 3'd5
    } kind_t;

    // Commands passed from the classifier to the executor
    typedef enum logic [2:0] {
        CMD_PRINT     = 3'd0,
        CMD_ENTER     = 3'd1,
        CMD_INTR      = 3'd2,
        CMD_CTRL_D    = 3'd3,
        CMD_ERASE_ONE = 3'd4,
        CMD_ERASE_ALL = 3'd5,
        CMD_EOF       = 3'd6
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t    op;
        logic [7:0] data;
    } cmd_t;

endpackage

// File: design/ule_front.sv
// Input classifier: tracks escape sequences and turns keyboard bytes into commands.
module ule_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,   // [7:0] rx_byte
    input  logic          s_axis_tuser,   // [0] end_of_input
    input  logic          q_full,
    output logic          q_push,
    output ule_pkg::cmd_t q_cmd
);
    import ule_pkg::*;

    typedef enum logic [2:0] {
        ESC_IDLE = 3'b001,
        ESC_SEEN = 3'b010,
        ESC_INTRO = 3'b100
    } esc_state_t;

    esc_state_t esc_reg, esc_next;
    logic       accept;
    logic       useful;
    cmd_op_t    op;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Classify the byte and advance the escape tracker
    always_comb
    begin
        esc_next = esc_reg;
        useful   = 1'b0;
        op       = CMD_PRINT;
        if (s_axis_tuser)
        begin
            useful   = 1'b1;
            op       = CMD_EOF;
            esc_next = ESC_IDLE;
        end
        else
        begin
            case (esc_reg)
                ESC_SEEN:
                begin
                    if (s_axis_tdata == CH_CSI_OPEN || s_axis_tdata == CH_SS3_OPEN)
                        esc_next = ESC_INTRO;
                    else
                        esc_next = ESC_IDLE;
                end
                ESC_INTRO:
                begin
                    esc_next = ESC_IDLE;
                end
                default:
                begin
                    if (s_axis_tdata == CH_ESC)
                        esc_next = ESC_SEEN;
                    else if (s_axis_tdata == CH_CR || s_axis_tdata == CH_LF)
                    begin
                        useful = 1'b1;
                        op     = CMD_ENTER;
                    end
                    else if (s_axis_tdata == CH_CTRL_C)
                    begin
                        useful = 1'b1;
                        op     = CMD_INTR;
                    end
                    else if (s_axis_tdata == CH_CTRL_D)
                    begin
                        useful = 1'b1;
                        op     = CMD_CTRL_D;
                    end
                    else if (s_axis_tdata == CH_BS || s_axis_tdata == CH_DEL)
                    begin
                        useful = 1'b1;
                        op     = CMD_ERASE_ONE;
                    end
                    else if (s_axis_tdata == CH_CTRL_U)
                    begin
                        useful = 1'b1;
                        op     = CMD_ERASE_ALL;
                    end
                    else if (s_axis_tdata >= CH_SPACE)
                    begin
                        useful = 1'b1;
                        op     = CMD_PRINT;
                    end
                end
            endcase
        end
    end

    assign q_push = accept && useful;
    assign q_cmd  = {op, s_axis_tdata};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            esc_reg <= ESC_IDLE;
        else if (accept)
            esc_reg <= esc_next;
    end

endmodule

// File: design/ule_cmdq.sv
// Two-entry command queue between the classifier and the executor.
module ule_cmdq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ule_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output ule_pkg::cmd_t head_cmd
);
    import ule_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full       = count_reg == 2'd2;
    assign head_valid = count_reg != 2'd0;
    assign head_cmd   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// File: design/ule_back.sv
// Command executor: owns the line store, erases code points and streams lines out.
module ule_back #(
    parameter int LINE_BYTES = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  ule_pkg::cmd_t cmd,
    output logic          cmd_pop,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [7:0]    m_axis_tdata,   // [7:0] value
    output logic [2:0]    m_axis_tuser,   // [2:0] kind
    output logic          m_axis_tlast
);
    import ule_pkg::*;

    localparam int LEN_W  = $clog2(LINE_BYTES + 1);
    localparam int ADDR_W = $clog2(LINE_BYTES);
    localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(LINE_BYTES);

    typedef enum logic [5:0] {
        ST_IDLE       = 6'b000001,
        ST_STREAM_RD  = 6'b000010,
        ST_STREAM_OUT = 6'b000100,
        ST_ERASE_RD   = 6'b001000,
        ST_ERASE_CHK  = 6'b010000,
        ST_ERASE_EMIT = 6'b100000
    } state_t;

    // Code point of a lead byte and up to three trailing continuation bytes
    function automatic logic [20:0] decode_cp(
        input logic [7:0] lead,
        input logic [7:0] c1,
        input logic [7:0] c2,
        input logic [7:0] c3,
        input logic [1:0] n_after
    );
        logic [20:0] cp;
        begin
            cp = {13'd0, lead};
            if (lead >= 8'hc0 && lead < 8'he0)
            begin
                if (n_after >= 2'd1)
                    cp = {10'd0, lead[4:0], c1[5:0]};
            end
            else if (lead >= 8'he0 && lead < 8'hf0)
            begin
                if (n_after >= 2'd2)
                    cp = {5'd0, lead[3:0], c1[5:0], c2[5:0]};
            end
            else if (lead >= 8'hf0 && lead < 8'hf8)
            begin
                if (n_after == 2'd3)
                    cp = {lead[2:0], c1[5:0], c2[5:0], c3[5:0]};
            end
            return cp;
        end
    endfunction

    // Terminal columns taken by a code point
    function automatic logic [1:0] cp_width(input logic [20:0] cp);
        logic [1:0] w;
        begin
            w = 2'd1;
            if (cp == 21'd0 ||
                (cp >= 21'h0300 && cp <= 21'h036f) ||
                (cp >= 21'h200b && cp <= 21'h200f) ||
                (cp >= 21'hfe00 && cp <= 21'hfe0f))
                w = 2'd0;
            else if ((cp >= 21'h1100 && cp <= 21'h115f) ||
                     (cp >= 21'h2329 && cp <= 21'h232a) ||
                     (cp >= 21'h2e80 && cp <= 21'ha4cf) ||
                     (cp >= 21'hac00 && cp <= 21'hd7a3) ||
                     (cp >= 21'hf900 && cp <= 21'hfaff) ||
                     (cp >= 21'hfe10 && cp <= 21'hfe6f) ||
                     (cp >= 21'hff00 && cp <= 21'hffe6) ||
                     (cp >= 21'h1f300 && cp <= 21'h1faff) ||
                     (cp >= 21'h20000 && cp <= 21'h3fffd))
                w = 2'd2;
            return w;
        end
    endfunction

    logic [7:0]        mem [LINE_BYTES];
    logic [7:0]        rd_data_reg;

    state_t            state_reg, state_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  idx_reg, idx_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [1:0]        n_after_reg, n_after_next;
    logic              all_reg, all_next;
    logic [7:0]        c1_reg, c1_next;
    logic [7:0]        c2_reg, c2_next;
    logic [7:0]        c3_reg, c3_next;
    logic [20:0]       cp_reg, cp_next;

    logic              out_valid_reg;
    logic [7:0]        out_value_reg;
    kind_t             out_kind_reg;
    logic              out_last_reg;

    logic              can_emit;
    logic              emit;
    kind_t             emit_kind;
    logic [7:0]        emit_value;
    logic              emit_last;
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [LEN_W-1:0]  len_m1;

    assign can_emit = !out_valid_reg || m_axis_tready;
    assign len_m1   = len_reg - LEN_W'(1);

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        len_next     = len_reg;
        idx_next     = idx_reg;
        pos_next     = pos_reg;
        n_after_next = n_after_reg;
        all_next     = all_reg;
        c1_next      = c1_reg;
        c2_next      = c2_reg;
        c3_next      = c3_reg;
        cp_next      = cp_reg;
        cmd_pop      = 1'b0;
        emit         = 1'b0;
        emit_kind    = KIND_ECHO;
        emit_value   = 8'd0;
        emit_last    = 1'b1;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = idx_reg[ADDR_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.op)
                        CMD_EOF, CMD_INTR:
                        begin
                            if (can_emit)
                            begin
                                cmd_pop   = 1'b1;
                                emit      = 1'b1;
                                emit_kind = (cmd.op == CMD_EOF) ? KIND_EOF : KIND_INTR;
                                len_next  = '0;
                            end
                        end
                        CMD_PRINT:
                        begin
                            if (len_reg == LEN_FULL)
                                cmd_pop = 1'b1;
                            else if (can_emit)
                            begin
                                cmd_pop    = 1'b1;
                                wr_en      = 1'b1;
                                emit       = 1'b1;
                                emit_kind  = KIND_ECHO;
                                emit_value = cmd.data;
                                len_next   = len_reg + LEN_W'(1);
                            end
                        end
                        CMD_ENTER:
                        begin
                            cmd_pop    = 1'b1;
                            idx_next   = '0;
                            state_next = ST_STREAM_RD;
                        end
                        CMD_CTRL_D:
                        begin
                            if (len_reg != '0)
                            begin
                                cmd_pop    = 1'b1;
                                idx_next   = '0;
                                state_next = ST_STREAM_RD;
                            end
                            else if (can_emit)
                            begin
                                cmd_pop   = 1'b1;
                                emit      = 1'b1;
                                emit_kind = KIND_EOF;
                            end
                        end
                        CMD_ERASE_ONE, CMD_ERASE_ALL:
                        begin
                            cmd_pop = 1'b1;
                            if (len_reg != '0)
                            begin
                                pos_next     = len_m1[ADDR_W-1:0];
                                n_after_next = 2'd0;
                                all_next     = cmd.op == CMD_ERASE_ALL;
                                state_next   = ST_ERASE_RD;
                            end
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end

            // Line delivery: one store read, then one result per byte
            ST_STREAM_RD:
            begin
                if (idx_reg == len_reg)
                begin
                    if (can_emit)
                    begin
                        emit       = 1'b1;
                        emit_kind  = KIND_ENDED;
                        len_next   = '0;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = ST_STREAM_OUT;
                end
            end

            ST_STREAM_OUT:
            begin
                if (can_emit)
                begin
                    emit       = 1'b1;
                    emit_kind  = KIND_LINE;
                    emit_value = rd_data_reg;
                    emit_last  = 1'b0;
                    idx_next   = idx_reg + LEN_W'(1);
                    state_next = ST_STREAM_RD;
                end
            end

            // Backward scan over continuation bytes to the lead byte
            ST_ERASE_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = pos_reg;
                state_next = ST_ERASE_CHK;
            end

            ST_ERASE_CHK:
            begin
                if (rd_data_reg[7:6] == 2'b10 && pos_reg != '0)
                begin
                    c3_next      = c2_reg;
                    c2_next      = c1_reg;
                    c1_next      = rd_data_reg;
                    n_after_next = (n_after_reg == 2'd3) ? 2'd3 : n_after_reg + 2'd1;
                    pos_next     = pos_reg - ADDR_W'(1);
                    state_next   = ST_ERASE_RD;
                end
                else
                begin
                    cp_next    = decode_cp(rd_data_reg, c1_reg, c2_reg, c3_reg, n_after_reg);
                    state_next = ST_ERASE_EMIT;
                end
            end

            ST_ERASE_EMIT:
            begin
                if (can_emit)
                begin
                    emit       = 1'b1;
                    emit_kind  = KIND_ERASE;
                    emit_value = {6'd0, cp_width(cp_reg)};
                    emit_last  = !all_reg || pos_reg == '0;
                    len_next   = LEN_W'(pos_reg);
                    if (all_reg && pos_reg != '0)
                    begin
                        pos_next     = pos_reg - ADDR_W'(1);
                        n_after_next = 2'd0;
                        state_next   = ST_ERASE_RD;
                    end
                    else
                        state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            idx_reg       <= '0;
            pos_reg       <= '0;
            n_after_reg   <= 2'd0;
            all_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            idx_reg     <= idx_next;
            pos_reg     <= pos_next;
            n_after_reg <= n_after_next;
            all_reg     <= all_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        c1_reg <= c1_next;
        c2_reg <= c2_next;
        c3_reg <= c3_next;
        cp_reg <= cp_next;
        if (emit)
        begin
            out_kind_reg  <= emit_kind;
            out_value_reg <= emit_value;
            out_last_reg  <= emit_last;
        end
    end

    // Line store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[len_reg[ADDR_W-1:0]] <= cmd.data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// File: design/utf8_terminal_line_editor.sv
// Top level of the UTF-8 terminal line editor.
//
// Input stream (s_axis): one keyboard byte per transfer in tdata, with tuser
// set when the source has closed. Output stream (m_axis): results with the
// kind in tuser, the echoed byte, line byte or erase column count in tdata,
// and tlast on the final result caused by one input byte.
// A classifier takes bytes, swallows escape sequences and queues commands in
// a two-entry queue; the executor works them off against the line store.
// Printable bytes (while the line has room), Ctrl-C and end of input reach
// m_axis_tvalid through the queue register and then the output register.
// Erase takes the command, reads and checks each stored byte scanned and
// emits one result per code point; line delivery reads and emits each stored
// byte, then the line end, both paced by the single read port of the line
// store. Bytes with no result are absorbed at one per cycle while the queue has room.
// Reset clears the line, the escape tracker, the queue and the output
// register; the line store itself needs no clearing. When the receiver holds
// tready low, the output register holds its result, the executor waits and
// the queue fills, after which s_axis_tready drops.
module utf8_terminal_line_editor #(
    parameter int LINE_BYTES = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    input  logic       s_axis_tuser,   // [0] end_of_input
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] value
    output logic [2:0] m_axis_tuser,   // [2:0] kind
    output logic       m_axis_tlast
);
    import ule_pkg::*;

    logic q_full;
    logic q_push;
    cmd_t q_cmd;
    logic q_pop;
    logic head_valid;
    cmd_t head_cmd;

    ule_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (q_cmd)
    );

    ule_cmdq u_cmdq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    ule_back #(
        .LINE_BYTES (LINE_BYTES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (head_valid),
        .cmd           (head_cmd),
        .cmd_pop       (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// File: tb/utf8_terminal_line_editor_test.sv
// Self-checking testbench for the UTF-8 terminal line editor.
`timescale 1ns / 1ps

import ule_pkg::*;

// One expected output transfer
typedef struct {
    kind_t      kind;
    logic [7:0] value;
    logic       last;
} editor_result_t;

// Tracks the edited line and the escape state, and queues the results each byte causes
class line_editor_scoreboard;
    editor_result_t want_q[$];
    logic [7:0]     line_bytes [64];
    int unsigned    line_len;
    int unsigned    line_cap;
    logic [1:0]     esc_phase;
    int unsigned    fail_count;
    int unsigned    bytes_seen;
    int unsigned    results_seen;
    int unsigned    kind_count [8];

    function new(int unsigned cap);
        line_cap = cap;
        line_len = 0;
        esc_phase = 2'd0;
        fail_count = 0;
        bytes_seen = 0;
        results_seen = 0;
        foreach (kind_count[i]) kind_count[i] = 0;
    endfunction

    function int unsigned pending();
        return want_q.size();
    endfunction

    function void push_result(kind_t k, logic [7:0] v);
        editor_result_t r;
        r.kind = k;
        r.value = v;
        r.last = 1'b0;
        want_q.insert(want_q.size(), r);
    endfunction

    // Code point starting at pos; malformed or cut-off sequences count as the lead byte
    function int unsigned code_point_at(int unsigned pos);
        int unsigned lead;
        int unsigned seq_len;
        int unsigned cp;
        int unsigned k;
        logic [7:0]  nb;
        lead = line_bytes[pos];
        if (lead < 'hc0) return lead;
        seq_len = (lead < 'he0) ? 2 : (lead < 'hf0) ? 3 : (lead < 'hf8) ? 4 : 1;
        if (seq_len == 1 || pos + seq_len > line_len) return lead;
        cp = lead & ((1 << (7 - seq_len)) - 1);
        for (k = 1; k < seq_len; k++) begin
            nb = line_bytes[pos + k];
            if (nb[7:6] != 2'b10) return lead;
            cp = (cp << 6) | nb[5:0];
        end
        return cp;
    endfunction

    // Terminal columns taken by a code point
    function logic [7:0] column_width(int unsigned cp);
        if (cp == 0 || (cp >= 'h0300 && cp <= 'h036f) ||
            (cp >= 'h200b && cp <= 'h200f) || (cp >= 'hfe00 && cp <= 'hfe0f))
            return 8'd0;
        if ((cp >= 'h1100 && cp <= 'h115f) || (cp >= 'h2329 && cp <= 'h232a) ||
            (cp >= 'h2e80 && cp <= 'ha4cf) || (cp >= 'hac00 && cp <= 'hd7a3) ||
            (cp >= 'hf900 && cp <= 'hfaff) || (cp >= 'hfe10 && cp <= 'hfe6f) ||
            (cp >= 'hff00 && cp <= 'hffe6) || (cp >= 'h1f300 && cp <= 'h1faff) ||
            (cp >= 'h20000 && cp <= 'h3fffd))
            return 8'd2;
        return 8'd1;
    endfunction

    // Drop the last code point (back over continuation bytes), return its width
    function logic [7:0] drop_last_code_point();
        int unsigned start;
        logic [7:0]  cols;
        start = line_len - 1;
        while (start > 0 && line_bytes[start][7:6] == 2'b10) start--;
        cols = column_width(code_point_at(start));
        line_len = start;
        return cols;
    endfunction

    function void stream_line();
        int unsigned k;
        for (k = 0; k < line_len; k++) push_result(KIND_LINE, line_bytes[k]);
        push_result(KIND_ENDED, 8'd0);
    endfunction

    // Accepted input transfer
    function void note_byte(logic [7:0] b, logic eoi);
        int unsigned first;
        first = want_q.size();
        bytes_seen++;
        if (eoi) begin
            push_result(KIND_EOF, 8'd0);
            line_len = 0;
            esc_phase = 2'd0;
        end
        else if (esc_phase != 2'd0) begin
            esc_phase = (esc_phase == 2'd1 && (b == CH_CSI_OPEN || b == CH_SS3_OPEN))
                        ? 2'd2 : 2'd0;
        end
        else if (b == CH_ESC) begin
            esc_phase = 2'd1;
        end
        else if (b == CH_CR || b == CH_LF) begin
            stream_line();
            line_len = 0;
        end
        else if (b == CH_CTRL_C) begin
            push_result(KIND_INTR, 8'd0);
            line_len = 0;
        end
        else if (b == CH_CTRL_D) begin
            if (line_len != 0) stream_line();
            else push_result(KIND_EOF, 8'd0);
            line_len = 0;
        end
        else if (b == CH_BS || b == CH_DEL) begin
            if (line_len != 0) push_result(KIND_ERASE, drop_last_code_point());
        end
        else if (b == CH_CTRL_U) begin
            while (line_len != 0) push_result(KIND_ERASE, drop_last_code_point());
        end
        else if (b >= CH_SPACE && line_len < line_cap) begin
            line_bytes[line_len] = b;
            line_len++;
            push_result(KIND_ECHO, b);
        end
        if (want_q.size() > first) want_q[want_q.size() - 1].last = 1'b1;
    endfunction

    // Accepted output transfer against the oldest expectation
    function void check_result(logic [2:0] kind, logic [7:0] value, logic last);
        editor_result_t want;
        results_seen++;
        if (want_q.size() == 0) begin
            fail_count++;
            if (fail_count <= 30)
                $display("%0t: unexpected result: expected none, got kind %0d value %02h last %0b",
                         $time, kind, value, last);
            return;
        end
        want = want_q.pop_front();
        kind_count[want.kind]++;
        if (kind !== want.kind) begin
            fail_count++;
            if (fail_count <= 30)
                $display("%0t: kind mismatch: expected %0d, got %0d", $time, want.kind, kind);
        end
        if (value !== want.value) begin
            fail_count++;
            if (fail_count <= 30)
                $display("%0t: value mismatch: expected %02h, got %02h", $time, want.value, value);
        end
        if (last !== want.last) begin
            fail_count++;
            if (fail_count <= 30)
                $display("%0t: last mismatch: expected %0b, got %0b", $time, want.last, last);
        end
    endfunction
endclass

module utf8_terminal_line_editor_test;

    localparam int          LINE_BYTES   = 32;
    localparam int unsigned CYCLE_LIMIT  = 2_000_000;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned DRAIN_CYCLES = 200;

    logic       clk;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // [7:0] rx_byte
    logic       s_axis_tuser;   // [0] end_of_input
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // [7:0] value
    logic [2:0] m_axis_tuser;   // [2:0] kind
    logic       m_axis_tlast;

    line_editor_scoreboard sb;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned items_sent;
    int unsigned cycle_count;
    int unsigned hold_left;
    bit          hold_request;

    // Code points on both sides of every width boundary above code point zero
    int unsigned cp_edges [46] = '{
        'h2ff, 'h300, 'h36f, 'h370, 'h10ff, 'h1100, 'h115f, 'h1160,
        'h200a, 'h200b, 'h200f, 'h2010, 'h2328, 'h2329, 'h232a, 'h232b,
        'h2e7f, 'h2e80, 'ha4cf, 'ha4d0, 'habff, 'hac00, 'hd7a3, 'hd7a4,
        'hf8ff, 'hf900, 'hfaff, 'hfb00, 'hfdff, 'hfe00, 'hfe0f, 'hfe10,
        'hfe6f, 'hfe70, 'hfeff, 'hff00, 'hffe6, 'hffe7, 'h1f2ff, 'h1f300,
        'h1faff, 'h1fb00, 'h1ffff, 'h20000, 'h3fffd, 'h3fffe
    };

    // Directed keys: {end_of_input, byte}
    logic [8:0] directed_keys [30] = '{
        {1'b1, 8'hff}, {1'b0, CH_CTRL_D}, {1'b0, CH_BS}, {1'b0, 8'h01},
        {1'b0, 8'hcc}, {1'b0, 8'h81},                              // combining mark
        {1'b0, 8'he4}, {1'b0, 8'hb8}, {1'b0, 8'h80},               // wide ideograph
        {1'b0, 8'hf0}, {1'b0, 8'h9f}, {1'b0, 8'h98}, {1'b0, 8'h80}, // emoji
        {1'b0, 8'hc0}, {1'b0, 8'h80},                              // overlong NUL
        {1'b0, 8'hff}, {1'b0, 8'he4},                              // bad lead, cut-off lead
        {1'b0, CH_DEL}, {1'b0, CH_BS}, {1'b0, CH_CTRL_U},
        {1'b0, 8'h7e}, {1'b0, CH_CR},
        {1'b0, CH_ESC}, {1'b0, CH_CSI_OPEN}, {1'b0, 8'h41},
        {1'b0, CH_SPACE}, {1'b0, CH_CTRL_D}, {1'b0, CH_CTRL_C},
        {1'b0, CH_ESC}, {1'b0, 8'h78}
    };

    utf8_terminal_line_editor #(
        .LINE_BYTES(LINE_BYTES)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one byte, with a random gap first, and wait for the transfer
    task automatic send_item(input logic [7:0] b, input logic eoi);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= eoi;
        do @(posedge clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic type_ascii(input int unsigned n);
        repeat (n) send_item(8'($urandom_range(32, 126)), 1'b0);
    endtask

    function automatic int unsigned pick_code_point();
        case ($urandom_range(0, 5))
            0, 1, 2: return cp_edges[$urandom_range(0, 45)];
            3:       return $urandom_range('h80, 'h7ff);
            4:       return $urandom_range('h800, 'hffff);
            default: return $urandom_range('h10000, 'h1fffff);
        endcase
    endfunction

    // UTF-8 encode; a broken sequence is cut short or gets a bad continuation
    task automatic send_code_point(input int unsigned cp, input bit broken);
        logic [7:0]  enc [4];
        int unsigned n;
        int unsigned k;
        if (cp < 'h800)
        begin
            enc[0] = 8'hc0 | 8'(cp >> 6);
            n = 2;
        end
        else if (cp < 'h10000)
        begin
            enc[0] = 8'he0 | 8'(cp >> 12);
            enc[1] = 8'h80 | 8'((cp >> 6) & 'h3f);
            n = 3;
        end
        else
        begin
            enc[0] = 8'hf0 | 8'(cp >> 18);
            enc[1] = 8'h80 | 8'((cp >> 12) & 'h3f);
            enc[2] = 8'h80 | 8'((cp >> 6) & 'h3f);
            n = 4;
        end
        enc[n - 1] = 8'h80 | 8'(cp & 'h3f);
        if (n == 3) enc[1] = 8'h80 | 8'((cp >> 6) & 'h3f);
        if (broken)
        begin
            if ($urandom_range(0, 1) == 0) n = $urandom_range(1, n - 1);
            else enc[$urandom_range(1, n - 1)] = 8'($urandom_range(0, 255));
        end
        for (k = 0; k < n; k++) send_item(enc[k], 1'b0);
    endtask

    task automatic send_escape();
        send_item(CH_ESC, 1'b0);
        if ($urandom_range(0, 9) < 6)
            send_item(($urandom_range(0, 1) != 0) ? CH_CSI_OPEN : CH_SS3_OPEN, 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // Mostly well-formed typing with edits and line ends, plus raw noise
    task automatic random_phase(input int unsigned n);
        int unsigned stop;
        int unsigned pick;
        stop = items_sent + n;
        while (items_sent < stop)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 28)
                type_ascii($urandom_range(1, 6));
            else if (pick < 48)
                send_code_point(pick_code_point(), $urandom_range(0, 6) == 0);
            else if (pick < 56)
                send_escape();
            else if (pick < 66)
                repeat ($urandom_range(1, 3))
                    send_item(($urandom_range(0, 1) != 0) ? CH_BS : CH_DEL, 1'b0);
            else if (pick < 70)
                send_item(CH_CTRL_U, 1'b0);
            else if (pick < 78)
                send_item(($urandom_range(0, 1) != 0) ? CH_CR : CH_LF, 1'b0);
            else if (pick < 81)
                send_item(CH_CTRL_C, 1'b0);
            else if (pick < 85)
                send_item(CH_CTRL_D, 1'b0);
            else if (pick < 87)
                send_item(8'($urandom_range(0, 255)), 1'b1);
            else if (pick < 94)
                send_item(8'($urandom_range(0, 255)), 1'b0);
            else if (pick < 97)
                type_ascii($urandom_range(28, 40));
            else
                send_item(8'($urandom_range(0, 31)), 1'b0);
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                hold_left = HOLD_CYCLES;
                while (hold_left != 0)
                begin
                    @(posedge clk);
                    hold_left--;
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Transfer monitor on both streams
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_byte(s_axis_tdata, s_axis_tuser);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d results outstanding",
                 cycle_count, sb.pending());
        $display("Some tests failed");
        $finish;
    end

    // Stimulus sequence
    initial
    begin
        sb = new(LINE_BYTES);
        items_sent = 0;
        hold_request = 1'b0;
        send_idle_pct = 13;
        recv_idle_pct = 84;
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= 8'd0;
        s_axis_tuser <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_keys[i])
            send_item(directed_keys[i][7:0], directed_keys[i][8]);
        random_phase(90);

        send_idle_pct = 84;
        recv_idle_pct = 13;
        random_phase(90);

        // Long receiver hold-off while full lines keep coming
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 1'b1;
        repeat (2)
        begin
            type_ascii(LINE_BYTES + 3);
            send_item(CH_CR, 1'b0);
        end
        random_phase(90);

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d keyboard bytes, checked %0d results in %0d cycles",
                 sb.bytes_seen, sb.results_seen, cycle_count);
        $display("echo %0d, erase %0d, line byte %0d, line end %0d, intr %0d, eof %0d",
                 sb.kind_count[KIND_ECHO], sb.kind_count[KIND_ERASE],
                 sb.kind_count[KIND_LINE], sb.kind_count[KIND_ENDED],
                 sb.kind_count[KIND_INTR], sb.kind_count[KIND_EOF]);
        if (sb.fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
